### hdl/separable_gaussian_blur_core_assert.svh
// Assertion macros shared by the smoothing core.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SEPARABLE_GAUSSIAN_BLUR_CORE_ASSERT_SVH
`define SEPARABLE_GAUSSIAN_BLUR_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define GSB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define GSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/gsb_pkg.sv
// Shared types, constants and helper functions for the separable smoothing core.
// No dependencies; every other .sv file imports this package.
package gsb_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int RADIUS     = 5;
    localparam int NUM_TAPS   = 2 * RADIUS + 1;
    localparam int NUM_COEF   = RADIUS + 1;

    localparam int PIX_W    = 16;
    localparam int FRAC_W   = 16;
    localparam int SIZE_W   = 7;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int W_DIM_W  = $clog2(MAX_WIDTH + 1);
    localparam int H_DIM_W  = $clog2(MAX_HEIGHT + 1);
    localparam int TAP_W    = $clog2(NUM_TAPS);
    localparam int DIST_W   = $clog2(NUM_COEF);
    localparam int PROD_W   = 2 * PIX_W;
    localparam int ACC_W    = PROD_W + $clog2(NUM_TAPS);
    localparam int PIPE_DEPTH = 4;
    localparam int DRAIN_W  = $clog2(PIPE_DEPTH);

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_SMOOTH = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd2;

    typedef logic [NUM_COEF-1:0][PIX_W-1:0] t_coef_arr;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 7'd64;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 7'd64;
    localparam t_coef_arr COEF_RESET = {16'd0, 16'd9, 16'd290, 16'd3538, 16'd15857, 16'd26143};

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [15:0] pixel_in;
    } t_req;

    typedef struct packed {
        logic [15:0] pixel_out;
        logic [1:0]  done_command;
    } t_rsp;

    typedef struct packed {
        logic              valid;
        logic              is_first;
        logic              is_last;
        logic              pass_v;
        logic [DIST_W-1:0] coef_idx;
        logic [ADDR_W-1:0] dst;
    } t_tap;

    typedef struct packed {
        logic              valid;
        logic              pass_v;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } t_wr;

    function automatic logic [DIST_W-1:0] tap_dist(input logic [TAP_W-1:0] k);
        logic [TAP_W-1:0] d;
        if (k >= TAP_W'(RADIUS)) begin
            d = k - TAP_W'(RADIUS);
        end else begin
            d = TAP_W'(RADIUS) - k;
        end
        return DIST_W'(d);
    endfunction

    function automatic logic [PIX_W-1:0] round_sat(input logic [ACC_W-1:0] acc);
        logic [ACC_W:0] s;
        s = {1'b0, acc} + (ACC_W + 1)'(1 << (FRAC_W - 1));
        if (|s[ACC_W:FRAC_W+PIX_W]) begin
            return '1;
        end
        return s[FRAC_W+PIX_W-1:FRAC_W];
    endfunction

endpackage

### hdl/gsb_seq.sv
// Pass sequencer: walks rows, columns and taps for the horizontal and vertical passes.
// Depends on gsb_pkg; drives store read addresses and the tap tags for gsb_mac.
module gsb_seq
    import gsb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [SIZE_W-1:0] i_width,
    input  logic [SIZE_W-1:0] i_height,
    output logic [ADDR_W-1:0] o_rd_addr,
    output t_tap              o_tap,
    output logic              o_done
);

    localparam int XP_W = ((COL_W > TAP_W) ? COL_W : TAP_W) + 1;
    localparam int YP_W = ((ROW_W > TAP_W) ? ROW_W : TAP_W) + 1;
    localparam logic [TAP_W-1:0]   TAP_LAST   = TAP_W'(NUM_TAPS - 1);
    localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(PIPE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HPASS,
        S_HDRAIN,
        S_VPASS,
        S_VDRAIN
    } t_state;

    t_state              r_state, n_state;
    logic [COL_W-1:0]    r_x, n_x;
    logic [ROW_W-1:0]    r_y, n_y;
    logic [TAP_W-1:0]    r_k, n_k;
    logic [DRAIN_W-1:0]  r_cnt, n_cnt;
    t_tap                r_tap, n_tap;
    logic                r_done, n_done;

    logic [W_DIM_W-1:0]  w_eff;
    logic [H_DIM_W-1:0]  h_eff;
    logic [COL_W-1:0]    w_last;
    logic [ROW_W-1:0]    h_last;
    logic [XP_W-1:0]     xp, xq;
    logic [YP_W-1:0]     yp, yq;
    logic [COL_W-1:0]    xi;
    logic [ROW_W-1:0]    yi;
    logic                issuing;

    always_comb begin
        if (i_width == '0) begin
            w_eff = W_DIM_W'(1);
        end else if (int'(i_width) > MAX_WIDTH) begin
            w_eff = W_DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = W_DIM_W'(i_width);
        end
        if (i_height == '0) begin
            h_eff = H_DIM_W'(1);
        end else if (int'(i_height) > MAX_HEIGHT) begin
            h_eff = H_DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = H_DIM_W'(i_height);
        end
        w_last = COL_W'(w_eff - W_DIM_W'(1));
        h_last = ROW_W'(h_eff - H_DIM_W'(1));

        xp = XP_W'(r_x) + XP_W'(r_k);
        xq = xp - XP_W'(RADIUS);
        if (xp < XP_W'(RADIUS)) begin
            xi = '0;
        end else if (xq >= XP_W'(w_eff)) begin
            xi = w_last;
        end else begin
            xi = COL_W'(xq);
        end

        yp = YP_W'(r_y) + YP_W'(r_k);
        yq = yp - YP_W'(RADIUS);
        if (yp < YP_W'(RADIUS)) begin
            yi = '0;
        end else if (yq >= YP_W'(h_eff)) begin
            yi = h_last;
        end else begin
            yi = ROW_W'(yq);
        end
    end

    assign issuing   = (r_state == S_HPASS) || (r_state == S_VPASS);
    assign o_rd_addr = (r_state == S_VPASS) ? {yi, r_x} : {r_y, xi};

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_done  = 1'b0;

        n_tap.valid    = issuing;
        n_tap.is_first = (r_k == '0);
        n_tap.is_last  = (r_k == TAP_LAST);
        n_tap.pass_v   = (r_state == S_VPASS);
        n_tap.coef_idx = tap_dist(r_k);
        n_tap.dst      = {r_y, r_x};

        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = S_HPASS;
                    n_x     = '0;
                    n_y     = '0;
                    n_k     = '0;
                end
            end
            S_HPASS, S_VPASS: begin
                if (r_k == TAP_LAST) begin
                    n_k = '0;
                    if (r_x == w_last) begin
                        n_x = '0;
                        if (r_y == h_last) begin
                            n_y     = '0;
                            n_cnt   = '0;
                            n_state = (r_state == S_HPASS) ? S_HDRAIN : S_VDRAIN;
                        end else begin
                            n_y = r_y + ROW_W'(1);
                        end
                    end else begin
                        n_x = r_x + COL_W'(1);
                    end
                end else begin
                    n_k = r_k + TAP_W'(1);
                end
            end
            S_HDRAIN: begin
                if (r_cnt == DRAIN_LAST) begin
                    n_state = S_VPASS;
                end else begin
                    n_cnt = r_cnt + DRAIN_W'(1);
                end
            end
            S_VDRAIN: begin
                if (r_cnt == DRAIN_LAST) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_cnt = r_cnt + DRAIN_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_x     <= '0;
            r_y     <= '0;
            r_k     <= '0;
            r_cnt   <= '0;
            r_tap   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_x     <= n_x;
            r_y     <= n_y;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
            r_tap   <= n_tap;
            r_done  <= n_done;
        end
    end

    assign o_tap  = r_tap;
    assign o_done = r_done;

endmodule

### hdl/gsb_mac.sv
// Shared multiply-accumulate unit: weight times pixel, summed over the taps of one pixel.
// Depends on gsb_pkg; returns the rounded, saturated pixel with its destination.
module gsb_mac
    import gsb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tap             i_tap,
    input  logic [PIX_W-1:0] i_data,
    input  t_coef_arr        i_coef,
    output t_wr              o_wr
);

    logic [PIX_W-1:0]  coef_sel;
    logic [PROD_W-1:0] r_prod;
    t_tap              r_ptag;
    logic [ACC_W-1:0]  r_acc;
    logic              r_wr_valid;
    logic              r_wr_pass;
    logic [ADDR_W-1:0] r_wr_addr;

    always_comb begin
        coef_sel = '0;
        for (int i = 0; i < NUM_COEF; i++) begin
            if (i_tap.coef_idx == DIST_W'(i)) begin
                coef_sel = i_coef[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptag     <= '0;
            r_wr_valid <= 1'b0;
        end else begin
            r_ptag     <= i_tap;
            r_wr_valid <= r_ptag.valid && r_ptag.is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(coef_sel) * PROD_W'(i_data);
        if (r_ptag.valid) begin
            if (r_ptag.is_first) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            r_wr_pass <= r_ptag.pass_v;
            r_wr_addr <= r_ptag.dst;
        end
    end

    always_comb begin
        o_wr.valid  = r_wr_valid;
        o_wr.pass_v = r_wr_pass;
        o_wr.addr   = r_wr_addr;
        o_wr.data   = round_sat(r_acc);
    end

endmodule

### hdl/separable_gaussian_blur_core.sv
// Write and read: one command per cycle unless busy; result strobe in the cycle after acceptance.
// Smooth: busy while the sequencer runs (one tap per cycle through the shared multiply-accumulate,
// 11 taps per pixel, two passes, a drain after each); strobe in the next cycle.
// Results cannot be stalled; each strobe lasts exactly one cycle.
// Reset (synchronous): sequencer idle, configuration at default values; stores keep contents.
// Holds configuration, frame and scratch stores; depends on gsb_pkg, gsb_seq and gsb_mac.
`include "separable_gaussian_blur_core_assert.svh"

module separable_gaussian_blur_core
    import gsb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  t_req                 i_req,
    output logic                 busy,
    output logic                 o_rsp_valid,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [SIZE_W-1:0] r_frame_width;
    logic [SIZE_W-1:0] r_frame_height;
    t_coef_arr         r_coef;

    logic              r_busy;
    logic              r_rsp_valid;
    logic [1:0]        r_rsp_cmd;
    logic              r_rsp_rd;

    logic [PIX_W-1:0]  r_frame_mem   [DEPTH];
    logic [PIX_W-1:0]  r_scratch_mem [DEPTH];
    logic [PIX_W-1:0]  r_frame_q;
    logic [PIX_W-1:0]  r_scratch_q;

    logic              accept;
    logic              go;
    logic              in_store;
    logic [ADDR_W-1:0] cmd_addr;
    logic [ADDR_W-1:0] seq_addr;
    logic [ADDR_W-1:0] frame_ra;
    logic              frame_we;
    logic [ADDR_W-1:0] frame_wa;
    logic [PIX_W-1:0]  frame_wd;
    logic              seq_done;
    t_tap              tap;
    t_wr               mac_wr;
    logic [PIX_W-1:0]  mac_data;

    assign accept   = start && !r_busy;
    assign go       = accept && (i_req.command == CMD_SMOOTH);
    assign in_store = (int'(i_req.col) < MAX_WIDTH) && (int'(i_req.row) < MAX_HEIGHT);
    assign cmd_addr = {ROW_W'(i_req.row), COL_W'(i_req.col)};
    assign frame_ra = r_busy ? seq_addr : cmd_addr;
    assign mac_data = tap.pass_v ? r_scratch_q : r_frame_q;

    always_comb begin
        frame_we = 1'b0;
        frame_wa = cmd_addr;
        frame_wd = i_req.pixel_in;
        if (mac_wr.valid && mac_wr.pass_v) begin
            frame_we = 1'b1;
            frame_wa = mac_wr.addr;
            frame_wd = mac_wr.data;
        end else if (accept && (i_req.command == CMD_WRITE) && in_store) begin
            frame_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_we) begin
            r_frame_mem[frame_wa] <= frame_wd;
        end
        r_frame_q <= r_frame_mem[frame_ra];
    end

    always_ff @(posedge i_clk) begin
        if (mac_wr.valid && !mac_wr.pass_v) begin
            r_scratch_mem[mac_wr.addr] <= mac_wr.data;
        end
        r_scratch_q <= r_scratch_mem[seq_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
            r_coef         <= COEF_RESET;
        end else if (i_cfg_we) begin
            priority if (i_cfg_idx == REG_WIDTH) begin
                r_frame_width <= i_cfg_data[SIZE_W-1:0];
            end else if (i_cfg_idx == REG_HEIGHT) begin
                r_frame_height <= i_cfg_data[SIZE_W-1:0];
            end else begin
                r_coef[DIST_W'(i_cfg_idx - REG_COEF0)] <= i_cfg_data[PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_rsp_cmd   <= CMD_WRITE;
            r_rsp_rd    <= 1'b0;
        end else begin
            r_rsp_valid <= (accept && !go) || seq_done;
            if (go) begin
                r_busy <= 1'b1;
            end else if (seq_done) begin
                r_busy <= 1'b0;
            end
            if (accept) begin
                r_rsp_cmd <= i_req.command;
                r_rsp_rd  <= (i_req.command == CMD_READ) && in_store;
            end
        end
    end

    assign busy               = r_busy;
    assign o_rsp_valid        = r_rsp_valid;
    assign o_rsp.pixel_out    = r_rsp_rd ? r_frame_q : '0;
    assign o_rsp.done_command = r_rsp_cmd;

    gsb_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .i_width   (r_frame_width),
        .i_height  (r_frame_height),
        .o_rd_addr (seq_addr),
        .o_tap     (tap),
        .o_done    (seq_done)
    );

    gsb_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tap   (tap),
        .i_data  (mac_data),
        .i_coef  (r_coef),
        .o_wr    (mac_wr)
    );

    `GSB_ASSERT_SAME(a_strobe_idle, o_rsp_valid, !busy, "result strobe while busy")
    `GSB_ASSERT_NEXT(a_smooth_busy, go, busy, "smooth request did not raise busy")
    `GSB_ASSERT_NEXT(a_quick_rsp, accept && !go, o_rsp_valid, "missing result strobe")
    `GSB_ASSERT_SAME(a_wb_busy, mac_wr.valid || tap.valid, r_busy, "pass activity while idle")

endmodule
